// ----- hdl/baro_sensor_compensation_core_macros.svh -----
// Assertion macros shared by the baro compensation RTL.
`ifndef BARO_SENSOR_COMPENSATION_CORE_MACROS_SVH
`define BARO_SENSOR_COMPENSATION_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk_i, quiet during reset.
`define BCOMP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bcomp assertion failed");
// Next-cycle implication, sampled on clk_i, quiet during reset.
`define BCOMP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bcomp assertion failed");
`else
`define BCOMP_ASSERT_IMP(lbl, ante, cons)
`define BCOMP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/bcomp_pkg.sv -----
// Shared types and constants for the barometer compensation pipeline.
`timescale 1ns / 1ps
`default_nettype none

package bcomp_pkg;

  localparam int unsigned RawW  = 24;
  localparam int unsigned CoefW = 16;
  localparam int unsigned TempW = 15;
  localparam int unsigned PresW = 17;

  // TEMP - 2000 is the pipeline's temperature offset; the very cold test
  // and square use TEMP + 1500 = (TEMP - 2000) + 3500.
  localparam logic signed [19:0] TEMP_REF     = 20'sd2000;
  localparam logic signed [19:0] TEMP_COLD_OF = 20'sd3500;

  localparam logic signed [14:0] TEMP_MIN = -15'sd4000;
  localparam logic signed [14:0] TEMP_MAX = 15'sd8500;
  localparam logic [16:0]        PRES_MIN = 17'd1000;
  localparam logic [16:0]        PRES_MAX = 17'd120000;

  typedef enum logic [2:0] {
    CFG_SENS     = 3'd0,
    CFG_OFF      = 3'd1,
    CFG_TCS      = 3'd2,
    CFG_TCO      = 3'd3,
    CFG_TREF     = 3'd4,
    CFG_TEMPSENS = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [CoefW-1:0] sens;
    logic [CoefW-1:0] off;
    logic [CoefW-1:0] tcs;
    logic [CoefW-1:0] tco;
    logic [CoefW-1:0] tref;
    logic [CoefW-1:0] tempsens;
  } coef_t;

  // Hand-off from the temperature/correction half to the pressure half.
  typedef struct packed {
    logic [RawW-1:0]   d1;
    logic signed [19:0] temp;
    logic signed [40:0] off;
    logic signed [39:0] sens;
  } mid_t;

  typedef struct packed {
    logic              clamped;
    logic [PresW-1:0]  pres;
    logic signed [TempW-1:0] temp;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/bcomp_temp_pipe.sv -----
// Temperature, second-order corrections, OFF and SENS: seven register stages.
`timescale 1ns / 1ps
`default_nettype none

module bcomp_temp_pipe (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [23:0]       d1_i,
  input  logic [23:0]       d2_i,
  input  bcomp_pkg::coef_t  coef_i,
  output logic              valid_o,
  output bcomp_pkg::mid_t   mid_o
);

  logic [6:0] vld_q;

  // S1: dT
  logic [23:0]        s1_d1_q;
  logic signed [24:0] s1_dt_d, s1_dt_q;
  // S2: dT*C6, dT^2
  logic [23:0]        s2_d1_q;
  logic signed [24:0] s2_dt_q;
  logic signed [41:0] s2_pt_d, s2_pt_q;
  logic signed [49:0] s2_sq_full;
  logic [47:0]        s2_sq_q;
  // S3: TEMP-2000, T2, C4*dT, C3*dT
  logic [23:0]        s3_d1_q;
  logic signed [41:0] s3_pt_adj;
  logic signed [18:0] s3_quo_q;
  logic [16:0]        s3_t2_q;
  logic signed [41:0] s3_tco_d, s3_tco_q;
  logic signed [41:0] s3_tcs_d, s3_tcs_q;
  // S4: cold offset, truncated coefficient terms
  logic [23:0]        s4_d1_q;
  logic signed [18:0] s4_quo_q;
  logic signed [19:0] s4_e_d, s4_e_q;
  logic [16:0]        s4_t2_q;
  logic signed [41:0] s4_tco_adj, s4_tcs_adj;
  logic signed [34:0] s4_tco_q;
  logic signed [33:0] s4_tcs_q;
  // S5: squares, final temperature, base OFF/SENS
  logic [23:0]        s5_d1_q;
  logic signed [37:0] s5_dsq_full;
  logic signed [39:0] s5_esq_full;
  logic [33:0]        s5_dsq_q;
  logic [35:0]        s5_esq_q;
  logic               s5_lt_q, s5_ltm_q;
  logic signed [19:0] s5_temp_d, s5_temp_q;
  logic signed [40:0] s5_offb_d, s5_offb_q;
  logic signed [39:0] s5_sensb_d, s5_sensb_q;
  // S6: OFF2, SENS2
  logic [23:0]        s6_d1_q;
  logic signed [19:0] s6_temp_q;
  logic signed [40:0] s6_offb_q;
  logic signed [39:0] s6_sensb_q;
  logic [36:0]        s6_x5;
  logic [38:0]        s6_e7;
  logic [39:0]        s6_e11;
  logic [39:0]        s6_off2_sum, s6_sens2_sum;
  logic [37:0]        s6_off2_q;
  logic [36:0]        s6_sens2_q;
  // S7
  bcomp_pkg::mid_t    mid_d, mid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[5:0], valid_i};
    end
  end

  always_comb begin
    s1_dt_d = $signed({1'b0, d2_i}) - $signed({1'b0, coef_i.tref, 8'h00});

    s2_pt_d    = s1_dt_q * $signed({1'b0, coef_i.tempsens});
    s2_sq_full = s1_dt_q * s1_dt_q;

    // divide by 2^23 toward zero: bias negatives by 2^23-1
    s3_pt_adj = s2_pt_q + $signed({19'd0, {23{s2_pt_q[41]}}});
    s3_tco_d  = $signed({1'b0, coef_i.tco}) * s2_dt_q;
    s3_tcs_d  = $signed({1'b0, coef_i.tcs}) * s2_dt_q;

    s4_e_d     = $signed({s3_quo_q[18], s3_quo_q}) + bcomp_pkg::TEMP_COLD_OF;
    s4_tco_adj = s3_tco_q + $signed({35'd0, {7{s3_tco_q[41]}}});
    s4_tcs_adj = s3_tcs_q + $signed({34'd0, {8{s3_tcs_q[41]}}});

    s5_dsq_full = s4_quo_q * s4_quo_q;
    s5_esq_full = s4_e_q * s4_e_q;
    s5_temp_d   = $signed({s4_quo_q[18], s4_quo_q}) + bcomp_pkg::TEMP_REF
                - (s4_quo_q[18] ? $signed({3'b000, s4_t2_q}) : 20'sd0);
    s5_offb_d   = $signed({9'd0, coef_i.off, 16'd0})
                + $signed({{6{s4_tco_q[34]}}, s4_tco_q});
    s5_sensb_d  = $signed({9'd0, coef_i.sens, 15'd0})
                + $signed({{6{s4_tcs_q[33]}}, s4_tcs_q});

    s6_x5  = {1'b0, s5_dsq_q, 2'b00} + {3'b000, s5_dsq_q};
    s6_e7  = {s5_esq_q, 3'b000} - {3'b000, s5_esq_q};
    s6_e11 = {1'b0, s5_esq_q, 3'b000} + {3'b000, s5_esq_q, 1'b0} + {4'd0, s5_esq_q};
    s6_off2_sum  = (s5_lt_q ? {4'd0, s6_x5[36:1]} : 40'd0)
                 + (s5_ltm_q ? {1'b0, s6_e7} : 40'd0);
    s6_sens2_sum = (s5_lt_q ? {5'd0, s6_x5[36:2]} : 40'd0)
                 + (s5_ltm_q ? {1'b0, s6_e11[39:1]} : 40'd0);

    mid_d.d1   = s6_d1_q;
    mid_d.temp = s6_temp_q;
    mid_d.off  = s6_offb_q - $signed({3'b000, s6_off2_q});
    mid_d.sens = s6_sensb_q - $signed({3'b000, s6_sens2_q});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_d1_q    <= d1_i;
      s1_dt_q    <= s1_dt_d;

      s2_d1_q    <= s1_d1_q;
      s2_dt_q    <= s1_dt_q;
      s2_pt_q    <= s2_pt_d;
      s2_sq_q    <= s2_sq_full[47:0];

      s3_d1_q    <= s2_d1_q;
      s3_quo_q   <= s3_pt_adj[41:23];
      s3_t2_q    <= s2_sq_q[47:31];
      s3_tco_q   <= s3_tco_d;
      s3_tcs_q   <= s3_tcs_d;

      s4_d1_q    <= s3_d1_q;
      s4_quo_q   <= s3_quo_q;
      s4_e_q     <= s4_e_d;
      s4_t2_q    <= s3_t2_q;
      s4_tco_q   <= s4_tco_adj[41:7];
      s4_tcs_q   <= s4_tcs_adj[41:8];

      s5_d1_q    <= s4_d1_q;
      s5_dsq_q   <= s5_dsq_full[33:0];
      s5_esq_q   <= s5_esq_full[35:0];
      s5_lt_q    <= s4_quo_q[18];
      s5_ltm_q   <= s4_e_q[19];
      s5_temp_q  <= s5_temp_d;
      s5_offb_q  <= s5_offb_d;
      s5_sensb_q <= s5_sensb_d;

      s6_d1_q    <= s5_d1_q;
      s6_temp_q  <= s5_temp_q;
      s6_offb_q  <= s5_offb_q;
      s6_sensb_q <= s5_sensb_q;
      s6_off2_q  <= s6_off2_sum[37:0];
      s6_sens2_q <= s6_sens2_sum[36:0];

      mid_q      <= mid_d;
    end
  end

  assign valid_o = vld_q[6];
  assign mid_o   = mid_q;

endmodule

`default_nettype wire

// ----- hdl/bcomp_pres_pipe.sv -----
// Pressure product, scaling and output clamping: six register stages.
`timescale 1ns / 1ps
`default_nettype none

`include "baro_sensor_compensation_core_macros.svh"

module bcomp_pres_pipe (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  bcomp_pkg::mid_t     mid_i,
  output logic                valid_o,
  output bcomp_pkg::result_t  res_o
);

  logic [5:0] vld_q;

  // P1: split D1*SENS into two partial products
  logic [43:0]        p1_plo_d, p1_plo_q;
  logic signed [44:0] p1_phi_d, p1_phi_q;
  logic signed [40:0] p1_off_q;
  logic signed [19:0] p1_temp_q;
  // P2: recombine
  logic signed [63:0] p2_prod_d, p2_prod_q;
  logic signed [40:0] p2_off_q;
  logic signed [19:0] p2_temp_q;
  // P3: /2^21
  logic signed [63:0] p3_adj;
  logic signed [42:0] p3_q1_q;
  logic signed [40:0] p3_off_q;
  logic signed [19:0] p3_temp_q;
  // P4: - OFF
  logic signed [43:0] p4_diff_d, p4_diff_q;
  logic signed [19:0] p4_temp_q;
  // P5: /2^15
  logic signed [43:0] p5_adj;
  logic signed [28:0] p5_pres_q;
  logic signed [19:0] p5_temp_q;
  // P6: clamp
  logic               p6_plo, p6_phi, p6_tlo, p6_thi;
  bcomp_pkg::result_t p6_res_d, p6_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_comb begin
    p1_plo_d  = mid_i.d1 * mid_i.sens[19:0];
    p1_phi_d  = $signed({1'b0, mid_i.d1}) * $signed(mid_i.sens[39:20]);

    p2_prod_d = $signed({p1_phi_q[43:0], 20'd0}) + $signed({20'd0, p1_plo_q});

    p3_adj    = p2_prod_q + $signed({43'd0, {21{p2_prod_q[63]}}});

    p4_diff_d = $signed({p3_q1_q[42], p3_q1_q}) - $signed({{3{p3_off_q[40]}}, p3_off_q});

    p5_adj    = p4_diff_q + $signed({29'd0, {15{p4_diff_q[43]}}});

    p6_plo = p5_pres_q < $signed({12'd0, bcomp_pkg::PRES_MIN});
    p6_phi = p5_pres_q > $signed({12'd0, bcomp_pkg::PRES_MAX});
    p6_tlo = p5_temp_q < bcomp_pkg::TEMP_MIN;
    p6_thi = p5_temp_q > bcomp_pkg::TEMP_MAX;

    priority if (p6_plo) begin
      p6_res_d.pres = bcomp_pkg::PRES_MIN;
    end else if (p6_phi) begin
      p6_res_d.pres = bcomp_pkg::PRES_MAX;
    end else begin
      p6_res_d.pres = p5_pres_q[16:0];
    end

    priority if (p6_tlo) begin
      p6_res_d.temp = bcomp_pkg::TEMP_MIN;
    end else if (p6_thi) begin
      p6_res_d.temp = bcomp_pkg::TEMP_MAX;
    end else begin
      p6_res_d.temp = p5_temp_q[14:0];
    end

    p6_res_d.clamped = p6_plo | p6_phi | p6_tlo | p6_thi;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_plo_q  <= p1_plo_d;
      p1_phi_q  <= p1_phi_d;
      p1_off_q  <= mid_i.off;
      p1_temp_q <= mid_i.temp;

      p2_prod_q <= p2_prod_d;
      p2_off_q  <= p1_off_q;
      p2_temp_q <= p1_temp_q;

      p3_q1_q   <= p3_adj[63:21];
      p3_off_q  <= p2_off_q;
      p3_temp_q <= p2_temp_q;

      p4_diff_q <= p4_diff_d;
      p4_temp_q <= p3_temp_q;

      p5_pres_q <= p5_adj[43:15];
      p5_temp_q <= p4_temp_q;

      p6_res_q  <= p6_res_d;
    end
  end

  assign valid_o = vld_q[5];
  assign res_o   = p6_res_q;

  `BCOMP_ASSERT_IMP(a_pres_in_range, vld_q[5], (p6_res_q.pres >= bcomp_pkg::PRES_MIN) && (p6_res_q.pres <= bcomp_pkg::PRES_MAX))
  `BCOMP_ASSERT_IMP(a_temp_in_range, vld_q[5], (p6_res_q.temp >= bcomp_pkg::TEMP_MIN) && (p6_res_q.temp <= bcomp_pkg::TEMP_MAX))
  `BCOMP_ASSERT_NXT(a_clamp_flag, en_i && vld_q[4] && (p6_plo || p6_phi || p6_tlo || p6_thi), p6_res_q.clamped)

endmodule

`default_nettype wire

// ----- hdl/bcomp_skid.sv -----
// Two-entry output skid stage between the pipeline and the result channel.
`timescale 1ns / 1ps
`default_nettype none

`include "baro_sensor_compensation_core_macros.svh"

module bcomp_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bcomp_pkg::result_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bcomp_pkg::result_t  out_data_o
);

  logic               out_valid_d, out_valid_q;
  logic               sp_valid_d, sp_valid_q;
  bcomp_pkg::result_t out_data_d, out_data_q;
  bcomp_pkg::result_t sp_data_d, sp_data_q;

  // ready depends on the spare slot only, so no path from out_ready_i
  assign in_ready_o = !sp_valid_q;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    sp_valid_d  = sp_valid_q;
    sp_data_d   = sp_data_q;
    if (!out_valid_q || out_ready_i) begin
      if (sp_valid_q) begin
        out_valid_d = 1'b1;
        out_data_d  = sp_data_q;
        sp_valid_d  = 1'b0;
      end else begin
        out_valid_d = in_valid_i;
        out_data_d  = in_data_i;
      end
    end else if (in_valid_i && !sp_valid_q) begin
      sp_valid_d = 1'b1;
      sp_data_d  = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sp_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sp_valid_q  <= sp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    sp_data_q  <= sp_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `BCOMP_ASSERT_IMP(a_spare_behind_out, sp_valid_q, out_valid_q)
  `BCOMP_ASSERT_NXT(a_spare_held, sp_valid_q && !out_ready_i, sp_valid_q && (sp_data_q == $past(sp_data_q)))
  `BCOMP_ASSERT_NXT(a_spare_catches, out_valid_q && !out_ready_i && in_valid_i && in_ready_o, sp_valid_q)

endmodule

`default_nettype wire

// ----- hdl/baro_sensor_compensation_core.sv -----
// Top level of the barometer second-order compensation core.
`timescale 1ns / 1ps
`default_nettype none

// Compensates one raw reading pair per item: s_axis_tdata carries D1 (pressure)
// and D2 (temperature), m_axis_tdata returns temperature in 0.01 C and pressure
// in Pa, both clamped, with m_axis_tuser flagging a clamp. The core takes one
// item every clock cycle while s_axis_tready is high and holds no state between
// items. From input accept to m_axis, an item passes through 7 stages of
// temperature, second-order correction and OFF/SENS math, 6 stages of the
// 24x40 pressure product (two partial products), scaling and clamping, and
// the output register. A two-entry skid buffer parts the pipeline from the
// result channel; s_axis_tready drops only once both entries are full, and
// then the whole pipeline holds. Six 16-bit calibration words (C1..C6) are
// written through the cfg port (index 0..5, others ignored, always ready);
// write them only while no item is in flight.

module baro_sensor_compensation_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // reading pair in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [23:0] raw_pressure, [47:24] raw_temperature
  // result out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [14:0] temperature_centi, [31:15] pressure_pa
  output logic        m_axis_tuser    // [0] clamped
);

  bcomp_pkg::coef_t   coef_d, coef_q;
  logic               pipe_en;
  logic               mid_valid;
  bcomp_pkg::mid_t    mid;
  logic               res_valid;
  bcomp_pkg::result_t res;
  bcomp_pkg::result_t out_res;

  // Calibration registers.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    coef_d = coef_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (bcomp_pkg::cfg_idx_e'(cfg_index_i))
        bcomp_pkg::CFG_SENS:     coef_d.sens     = cfg_data_i;
        bcomp_pkg::CFG_OFF:      coef_d.off      = cfg_data_i;
        bcomp_pkg::CFG_TCS:      coef_d.tcs      = cfg_data_i;
        bcomp_pkg::CFG_TCO:      coef_d.tco      = cfg_data_i;
        bcomp_pkg::CFG_TREF:     coef_d.tref     = cfg_data_i;
        bcomp_pkg::CFG_TEMPSENS: coef_d.tempsens = cfg_data_i;
        default: ;  // unused indexes: write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else begin
      coef_q <= coef_d;
    end
  end

  // The whole pipeline moves together whenever the skid has a free slot.
  assign s_axis_tready = pipe_en;

  bcomp_temp_pipe u_temp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (s_axis_tvalid),
    .d1_i    (s_axis_tdata[23:0]),
    .d2_i    (s_axis_tdata[47:24]),
    .coef_i  (coef_q),
    .valid_o (mid_valid),
    .mid_o   (mid)
  );

  bcomp_pres_pipe u_pres (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (mid_valid),
    .mid_i   (mid),
    .valid_o (res_valid),
    .res_o   (res)
  );

  bcomp_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_ready_o  (pipe_en),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata = {out_res.pres, out_res.temp};
  assign m_axis_tuser = out_res.clamped;

endmodule

`default_nettype wire
